### src/assert_macros.svh
// Assertion helper macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/fxfc_pkg.sv
// ----------------------------------------------------------------------------
// fxfc_pkg
// Types and constants for the s15.16 fixed / single precision converter.
// ----------------------------------------------------------------------------
package fxfc_pkg;

   localparam int unsigned FracBits = 16;

   typedef enum logic {
      CMD_FIX_TO_FLT = 1'b0,
      CMD_FLT_TO_FIX = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        saturated;
   } rsp_type;

   localparam logic [31:0] FixMaxPos = 32'h7FFF_FFFF;
   localparam logic [31:0] FixMaxNeg = 32'h8000_0000;

endpackage

### src/fxfc_stream_if.sv
// ----------------------------------------------------------------------------
// fxfc_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface fxfc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/fixed16_float32_converter_core.sv
// ----------------------------------------------------------------------------
// fixed16_float32_converter_core
// Signed 16.16 fixed point <-> IEEE 754 single precision converter.
// ----------------------------------------------------------------------------
// The request is captured in an input register, converted by combinational
// logic (leading-one search, shift, round to nearest even, or shift, truncate
// and saturate) and held in a result register. A stalled result does not
// block intake while the input register is free, so the throughput is one
// request per clock while the response side takes them. Float-to-fixed
// saturates out-of-range values and gives zero for NaN; saturated marks both.
`include "assert_macros.svh"

module fixed16_float32_converter_core (
   input logic clock,
   input logic reset,
   fxfc_stream_if.sink   req,
   fxfc_stream_if.source rsp
);
   import fxfc_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff, in_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;
   logic    adv;
   rsp_type conv;

   // result register takes a new value when empty or being drained
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = !in_vld_ff || adv;
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_in      = in_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (adv) begin
         out_vld_in = in_vld_ff;
         out_in     = conv;
         in_vld_in  = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_vld_in = 1'b1;
         in_in     = req.data;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // fixed to float
   logic        f_neg;
   logic [31:0] f_mag;
   logic [4:0]  f_top;
   logic [31:0] f_norm;
   logic [23:0] f_kept;
   logic        f_grd, f_stk, f_up;
   logic [24:0] f_mant;
   logic [31:0] f_res;

   always_comb begin
      f_neg = in_ff.operand[31];
      f_mag = f_neg ? (32'd0 - in_ff.operand) : in_ff.operand;
      f_top = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (f_mag[b]) f_top = 5'(b);
      end
      f_norm = f_mag << (5'd31 - f_top);
      f_kept = f_norm[31:8];
      f_grd  = f_norm[7];
      f_stk  = |f_norm[6:0];
      f_up   = f_grd && (f_stk || f_kept[0]);
      f_mant = {1'b0, f_kept} + {24'd0, f_up};
      if (f_mag == 32'd0) begin
         f_res = 32'd0;
      end else begin
         // exponent field = top + 127 - 16; mantissa carry spills into it
         f_res = {f_neg, 31'd0}
               + ({24'd0, 3'd0, f_top} + 32'd110 << 23)
               + {7'd0, f_mant};
      end
   end

   // float to fixed
   logic        g_neg, g_nan, g_big;
   logic [7:0]  g_ex;
   logic [23:0] g_m;
   logic [8:0]  g_exe;
   logic [32:0] g_mag;
   logic [31:0] g_res;
   logic        g_sat;

   always_comb begin
      g_neg = in_ff.operand[31];
      g_ex  = in_ff.operand[30:23];
      g_nan = (g_ex == 8'hFF) && (in_ff.operand[22:0] != 23'd0);
      g_m   = (g_ex == 8'd0) ? {1'b0, in_ff.operand[22:0]} : {1'b1, in_ff.operand[22:0]};
      g_exe = (g_ex == 8'd0) ? 9'd1 : {1'b0, g_ex};
      g_big = g_exe > 9'd142;
      g_mag = 33'd0;
      if (g_exe >= 9'd134) begin
         g_mag = {9'd0, g_m} << (g_exe - 9'd134);
      end else if (g_exe > 9'd102) begin
         g_mag = {9'd0, g_m >> (9'd134 - g_exe)};
      end
      g_sat = 1'b0;
      if (g_nan) begin
         g_res = 32'd0;
         g_sat = 1'b1;
      end else if (!g_neg) begin
         if (g_big || g_mag > {1'b0, FixMaxPos}) begin
            g_res = FixMaxPos;
            g_sat = 1'b1;
         end else begin
            g_res = g_mag[31:0];
         end
      end else if (g_big || g_mag > {1'b0, FixMaxNeg}) begin
         g_res = FixMaxNeg;
         g_sat = 1'b1;
      end else begin
         g_res = 32'd0 - g_mag[31:0];
      end
   end

   always_comb begin
      case (in_ff.command)
         CMD_FIX_TO_FLT: conv = '{result: f_res, saturated: 1'b0};
         default:        conv = '{result: g_res, saturated: g_sat};
      endcase
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "response changed while stalled")
   `ASSERT_ALWAYS(a_no_drop, clock, reset, !(in_vld_ff && !req.ready && !out_vld_ff), "input held with empty output")
   `ASSERT_ALWAYS(a_sat_mode, clock, reset, !(rsp.valid && rsp.data.saturated) || rsp.data.result == 32'd0 || rsp.data.result == FixMaxPos || rsp.data.result == FixMaxNeg, "saturated with non-limit result")

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives fixed/float conversion requests through the converter with random
// idling on both sides, checks each response against a table or predictor.
// ----------------------------------------------------------------------------
module tb;
   import fxfc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 400000;

   typedef struct {
      cmd_type     command;
      logic [31:0] operand;
      logic        known;
      logic [31:0] result;
      logic        saturated;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned cycles = 0;
   int unsigned errors = 0;
   bit          hold_rsp = 1'b0;
   bit          calm = 1'b0;
   rsp_type     expected_q[$];

   fxfc_stream_if #(.payload_type(req_type)) req ();
   fxfc_stream_if #(.payload_type(rsp_type)) rsp ();

   fixed16_float32_converter_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] fixed_to_single(logic [31:0] pattern);
      logic [31:0] mag;
      logic [31:0] kept;
      logic [31:0] rem;
      logic [31:0] half;
      logic [31:0] mant;
      int          top;
      int          sh;
      mag = pattern[31] ? -pattern : pattern;
      if (mag == 0) return 32'h0;
      top = 0;
      for (int b = 0; b < 32; b++) if (mag[b]) top = b;
      if (top <= 23) begin
         mant = mag << (23 - top);
      end else begin
         sh = top - 23;
         kept = mag >> sh;
         rem = mag & ((32'h1 << sh) - 1);
         half = 32'h1 << (sh - 1);
         if (rem > half || (rem == half && kept[0])) kept++;
         mant = kept;
      end
      // mantissa carry into the exponent is intended
      return ({31'h0, pattern[31]} << 31) + ((top + 127 - FracBits - 1) << 23) + mant;
   endfunction

   function automatic rsp_type single_to_fixed(logic [31:0] pattern);
      rsp_type     r;
      logic [7:0]  ex;
      logic [31:0] m;
      logic [63:0] mag;
      int          sh;
      r.saturated = 1'b0;
      ex = pattern[30:23];
      if (ex == 8'hFF && pattern[22:0] != 0) begin
         r.result = 32'h0;
         r.saturated = 1'b1;
         return r;
      end
      m = (ex == 0) ? {9'h0, pattern[22:0]} : {9'h1, pattern[22:0]};
      sh = ((ex == 0) ? 1 : int'(ex)) - (150 - FracBits);
      if (sh > 8) mag = 64'h1 << 33;
      else if (sh >= 0) mag = {32'h0, m} << sh;
      else if (sh <= -32) mag = 0;
      else mag = {32'h0, m >> (-sh)};
      if (!pattern[31]) begin
         if (mag > 64'h7FFF_FFFF) begin
            r.result = FixMaxPos;
            r.saturated = 1'b1;
         end else begin
            r.result = mag[31:0];
         end
      end else if (mag > 64'h8000_0000) begin
         r.result = FixMaxNeg;
         r.saturated = 1'b1;
      end else begin
         r.result = -mag[31:0];
      end
      return r;
   endfunction

   function automatic rsp_type convert(cmd_type command, logic [31:0] operand);
      rsp_type r;
      if (command == CMD_FIX_TO_FLT) begin
         r.result = fixed_to_single(operand);
         r.saturated = 1'b0;
      end else begin
         r = single_to_fixed(operand);
      end
      return r;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 13);
   endfunction

   // directed requests: extremes, both commands and every special case
   vector_type directed[] = '{
      '{CMD_FIX_TO_FLT, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h0001_0000, 1'b1, 32'h3F80_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'hFFFF_0000, 1'b1, 32'hBF80_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h8000_0000, 1'b1, 32'hC700_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h0000_0001, 1'b1, 32'h3780_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'hFFFF_FFFF, 1'b1, 32'hB780_0000, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h0100_0001, 1'b0, 32'h0, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h0300_0002, 1'b0, 32'h0, 1'b0},
      '{CMD_FIX_TO_FLT, 32'h01FF_FFFF, 1'b0, 32'h0, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h7FC0_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{CMD_FLT_TO_FIX, 32'hFF80_0001, 1'b1, 32'h0000_0000, 1'b1},
      '{CMD_FLT_TO_FIX, 32'h7F80_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{CMD_FLT_TO_FIX, 32'hFF80_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{CMD_FLT_TO_FIX, 32'h4700_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{CMD_FLT_TO_FIX, 32'hC700_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{CMD_FLT_TO_FIX, 32'hC700_0001, 1'b1, 32'h8000_0000, 1'b1},
      '{CMD_FLT_TO_FIX, 32'h46FF_FFFF, 1'b1, 32'h7FFF_FF80, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h3780_0000, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_FLT_TO_FIX, 32'h3F80_0000, 1'b1, 32'h0001_0000, 1'b0},
      '{CMD_FLT_TO_FIX, 32'hBFC0_0000, 1'b1, 32'hFFFE_8000, 1'b0}
   };

   task automatic send(cmd_type command, logic [31:0] operand, logic known,
                       rsp_type typed);
      while (idle_now()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{command: command, operand: operand};
      do @(posedge clock); while (!req.ready);
      expected_q.push_back(known ? typed : convert(command, operand));
   endtask

   function automatic logic [31:0] random_float();
      logic [31:0] p;
      p = $urandom();
      // keep most exponents near the fixed range
      if ($urandom_range(3) != 0) p[30:23] = 8'(112 + $urandom_range(40));
      return p;
   endfunction

   initial begin
      rsp_type     typed;
      cmd_type     command;
      logic [31:0] operand;
      req.valid = 1'b0;
      req.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         typed.result = directed[i].result;
         typed.saturated = directed[i].saturated;
         send(directed[i].command, directed[i].operand, directed[i].known, typed);
      end
      for (int i = 0; i < 550; i++) begin
         if (i == 150) hold_rsp <= 1'b1;
         if (i == 300) begin
            // pause until every response is back
            req.valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         calm = (i >= 400 && i < 470);
         command = cmd_type'($urandom_range(1));
         if (command == CMD_FLT_TO_FIX) operand = random_float();
         else if ($urandom_range(1)) operand = $urandom() >> $urandom_range(31);
         else operand = $urandom();
         send(command, operand, 1'b0, typed);
      end
      req.valid <= 1'b0;
      calm = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hold off the response side for a long stretch
   initial begin
      wait (hold_rsp);
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      rsp.ready <= !reset && !hold_rsp && !idle_now();
   end

   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response %h", rsp.data);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp.data.result !== want.result) begin
               $error("result expected %h actual %h", want.result, rsp.data.result);
               errors++;
            end
            if (rsp.data.saturated !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated,
                      rsp.data.saturated);
               errors++;
            end
         end
      end
   end
endmodule

### fixed16_float32_converter_core.f
+incdir+src
src/fxfc_pkg.sv
src/fxfc_stream_if.sv
src/fixed16_float32_converter_core.sv
tb/tb.sv
